// ----- rtl/core/tcs_pkg.sv -----
// shared types and constants of the triangle column span core
package tcs_pkg;

  localparam int COORD_W = 16;
  localparam int FRAC_W  = 4;
  localparam int COL_W   = 12;
  localparam int SPAN_W  = 12;
  localparam int COLOR_W = 24;
  localparam int NUM_W   = 36;
  localparam int DEN_W   = 21;
  localparam int ADDR_W  = 5;

  localparam logic [2:0] REG_AX    = 3'd0;
  localparam logic [2:0] REG_AY    = 3'd1;
  localparam logic [2:0] REG_BX    = 3'd2;
  localparam logic [2:0] REG_BY    = 3'd3;
  localparam logic [2:0] REG_CX    = 3'd4;
  localparam logic [2:0] REG_CY    = 3'd5;
  localparam logic [2:0] REG_COLOR = 3'd6;

  typedef struct packed {
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic signed [COORD_W-1:0] bx;
    logic signed [COORD_W-1:0] by;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic [COLOR_W-1:0]        color;
  } cfg_t;

  // one edge division in flight: partial remainder, numerator bits
  // shifting out on top while quotient bits shift in below
  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [NUM_W-1:0] nq;
    logic [DEN_W-1:0] den;
    logic             neg;
    logic             dz;
  } lane_t;

  typedef struct packed {
    lane_t bot;
    lane_t top;
    logic  hit;
  } div_t;

endpackage

// ----- rtl/core/tcs_regs.sv -----
// configuration register file with its apb-style port
module tcs_regs
  import tcs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [2:0] idx;
  logic       wr;

  assign pready = 1'b1;
  assign idx    = paddr[ADDR_W-1:2];
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr) begin
      unique case (idx)
        REG_AX:    cfg.ax    <= pwdata[COORD_W-1:0];
        REG_AY:    cfg.ay    <= pwdata[COORD_W-1:0];
        REG_BX:    cfg.bx    <= pwdata[COORD_W-1:0];
        REG_BY:    cfg.by    <= pwdata[COORD_W-1:0];
        REG_CX:    cfg.cx    <= pwdata[COORD_W-1:0];
        REG_CY:    cfg.cy    <= pwdata[COORD_W-1:0];
        REG_COLOR: cfg.color <= pwdata[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_AX:    prdata = 32'({16'b0, cfg.ax});
      REG_AY:    prdata = 32'({16'b0, cfg.ay});
      REG_BX:    prdata = 32'({16'b0, cfg.bx});
      REG_BY:    prdata = 32'({16'b0, cfg.by});
      REG_CX:    prdata = 32'({16'b0, cfg.cx});
      REG_CY:    prdata = 32'({16'b0, cfg.cy});
      REG_COLOR: prdata = 32'({8'b0, cfg.color});
      default:   prdata = 32'b0;
    endcase
  end

endmodule

// ----- rtl/core/tcs_setup.sv -----
// front stages: vertex rotation, segment pick, edge numerators and divisors
module tcs_setup
  import tcs_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  cfg_t                    cfg,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [COL_W-1:0] in_col,
  output logic                    out_valid,
  input  logic                    out_ready,
  output div_t                    out_data
);

  // stage 1 combinational
  logic signed [COORD_W-1:0] ax, ay, bx, by, cx, cy;
  logic                      b_first, c_first, b_mid, seg1, seg2;
  logic signed [COORD_W:0]   ax_up;
  logic signed [COL_W:0]     left, mid, right, colw;

  // stage 1 registers
  logic                      v1;
  logic signed [COORD_W-1:0] bpx, bpy, bqx, bqy, tpx, tpy, tqx, tqy, xq;
  logic                      hit1;

  // stage 2
  logic                      v2;
  logic signed [COORD_W:0]   bdx_c, bdy_c, bxm_c, tdx_c, tdy_c, txm_c;
  logic signed [COORD_W:0]   bdx, tdx;
  logic signed [32:0]        bp1, tp1;
  logic signed [33:0]        bp2, tp2;
  logic                      hit2;

  logic                      v3;
  logic                      r1, r2, r3;

  assign r3       = !v3 || out_ready;
  assign r2       = !v2 || r3;
  assign r1       = !v1 || r2;
  assign in_ready = r1;
  assign out_valid = v3;

  always_comb begin
    b_first = (cfg.bx < cfg.ax) && (cfg.bx <= cfg.cx);
    c_first = !b_first && (cfg.cx < cfg.ax) && (cfg.cx <= cfg.bx);
    if (b_first) begin
      ax = cfg.bx; ay = cfg.by; bx = cfg.cx; by = cfg.cy; cx = cfg.ax; cy = cfg.ay;
    end else if (c_first) begin
      ax = cfg.cx; ay = cfg.cy; bx = cfg.ax; by = cfg.ay; cx = cfg.bx; cy = cfg.by;
    end else begin
      ax = cfg.ax; ay = cfg.ay; bx = cfg.bx; by = cfg.by; cx = cfg.cx; cy = cfg.cy;
    end
    b_mid = bx < cx;
    // ceiling of the left vertex, floors of the others
    ax_up = (COORD_W+1)'(ax) + (COORD_W+1)'((1 << FRAC_W) - 1);
    left  = ax_up[COORD_W:FRAC_W];
    mid   = b_mid ? (COL_W+1)'(signed'(bx[COORD_W-1:FRAC_W]))
                  : (COL_W+1)'(signed'(cx[COORD_W-1:FRAC_W]));
    right = b_mid ? (COL_W+1)'(signed'(cx[COORD_W-1:FRAC_W]))
                  : (COL_W+1)'(signed'(bx[COORD_W-1:FRAC_W]));
    colw  = (COL_W+1)'(in_col);
    seg1  = (b_mid ? (ax != bx) : (ax != cx)) && (colw >= left) && (colw <= mid);
    seg2  = !seg1 && (colw >= mid + (COL_W+1)'(1)) && (colw <= right);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (r1) begin
      v1 <= in_valid;
    end
    if (r1 && in_valid) begin
      hit1 <= seg1 || seg2;
      xq   <= {in_col, {FRAC_W{1'b0}}};
      // bottom edge: b-c only for the second half with b in the middle
      if (b_mid && !seg1) begin
        bpx <= bx; bpy <= by; bqx <= cx; bqy <= cy;
      end else begin
        bpx <= ax; bpy <= ay; bqx <= bx; bqy <= by;
      end
      // top edge: b-c only for the second half with c in the middle
      if (!b_mid && !seg1) begin
        tpx <= bx; tpy <= by; tqx <= cx; tqy <= cy;
      end else begin
        tpx <= ax; tpy <= ay; tqx <= cx; tqy <= cy;
      end
    end
  end

  assign bdx_c = (COORD_W+1)'(bqx) - (COORD_W+1)'(bpx);
  assign bdy_c = (COORD_W+1)'(bqy) - (COORD_W+1)'(bpy);
  assign bxm_c = (COORD_W+1)'(xq) - (COORD_W+1)'(bpx);
  assign tdx_c = (COORD_W+1)'(tqx) - (COORD_W+1)'(tpx);
  assign tdy_c = (COORD_W+1)'(tqy) - (COORD_W+1)'(tpy);
  assign txm_c = (COORD_W+1)'(xq) - (COORD_W+1)'(tpx);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (r2) begin
      v2 <= v1;
    end
    if (r2 && v1) begin
      bdx  <= bdx_c;
      tdx  <= tdx_c;
      bp1  <= 33'(bpy) * 33'(bdx_c);
      bp2  <= 34'(bdy_c) * 34'(bxm_c);
      tp1  <= 33'(tpy) * 33'(tdx_c);
      tp2  <= 34'(tdy_c) * 34'(txm_c);
      hit2 <= hit1;
    end
  end

  function automatic lane_t mk_lane(input logic signed [32:0] p1,
                                    input logic signed [33:0] p2,
                                    input logic signed [COORD_W:0] dx);
    logic signed [NUM_W-1:0] n, nn;
    logic [COORD_W:0]        adx;
    lane_t                   l;
    n      = NUM_W'(p1) + NUM_W'(p2);
    nn     = dx[COORD_W] ? -n : n;
    adx    = dx[COORD_W] ? (COORD_W+1)'(-dx) : (COORD_W+1)'(dx);
    l.rem  = '0;
    l.neg  = nn[NUM_W-1];
    l.nq   = nn[NUM_W-1] ? NUM_W'(-nn) : NUM_W'(nn);
    l.den  = {adx, {FRAC_W{1'b0}}};
    l.dz   = (dx == '0);
    return l;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (r3) begin
      v3 <= v2;
    end
    if (r3 && v2) begin
      out_data.bot <= mk_lane(bp1, bp2, bdx);
      out_data.top <= mk_lane(tp1, tp2, tdx);
      out_data.hit <= hit2;
    end
  end

endmodule

// ----- rtl/core/tcs_div.sv -----
// pipelined restoring divider, one quotient bit per stage, two lanes
module tcs_div
  import tcs_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  div_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output div_t out_data
);

  logic v   [0:NUM_W-1];
  div_t st  [0:NUM_W-1];
  logic sv  [0:NUM_W-1];
  div_t src [0:NUM_W-1];
  logic rdy [0:NUM_W];

  function automatic lane_t step(input lane_t l);
    logic [DEN_W:0] trial;
    logic           ge;
    lane_t          o;
    trial = {l.rem, l.nq[NUM_W-1]};
    ge    = trial >= {1'b0, l.den};
    o     = l;
    o.rem = ge ? DEN_W'(trial - {1'b0, l.den}) : DEN_W'(trial);
    o.nq  = {l.nq[NUM_W-2:0], ge};
    return o;
  endfunction

  assign rdy[NUM_W] = out_ready;
  assign in_ready   = rdy[0];
  assign out_valid  = v[NUM_W-1];
  assign out_data   = st[NUM_W-1];

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    if (k == 0) begin : g_first
      assign sv[k]  = in_valid;
      assign src[k] = in_data;
    end else begin : g_next
      assign sv[k]  = v[k-1];
      assign src[k] = st[k-1];
    end
    assign rdy[k] = !v[k] || rdy[k+1];

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (rdy[k]) begin
        v[k] <= sv[k];
      end
      if (rdy[k] && sv[k]) begin
        st[k].bot <= step(src[k].bot);
        st[k].top <= step(src[k].top);
        st[k].hit <= src[k].hit;
      end
    end
  end

endmodule

// ----- rtl/core/triangle_column_span_core.sv -----
// top level of the triangle column span core
//
//  channel  | direction | payload
//  ---------+-----------+---------------------------------------------------
//  s_*      | in        | tdata: column
//  m_*      | out       | tuser: covered; tdata: span_bottom, span_top, color
//  apb      | in        | vertex a/b/c x,y and fill color registers
//
// each request passes 40 register stages: 3 setup stages, 36 divider
// stages (one quotient bit each, set by the numerator width) and one output
// stage; the accepting edge loads the first. one request enters per clock
// while the output is not stalled.
// reset clears all valid bits and the registers; payload is not reset.
// a stall at the output backs up stage by stage; bubbles are squeezed out
// so input is taken while any stage is free.
module triangle_column_span_core
  import tcs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // input stream
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [15:0]       s_tdata,   // [11:0] column
  // result stream
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [47:0]       m_tdata,   // [11:0] span_bottom, [23:12] span_top,
                                       // [47:24] pixel_color
  output logic              m_tuser,   // [0] covered
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfg_t cfg;
  logic su_valid, su_ready, dv_valid, dv_ready;
  div_t su_data, dv_data;

  logic signed [NUM_W:0] bot, top;
  logic                  cov;
  logic [SPAN_W-1:0]     bot_s, top_s;

  tcs_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  tcs_setup u_setup (
    .clk, .rst, .cfg,
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_col    (s_tdata[COL_W-1:0]),
    .out_valid (su_valid),
    .out_ready (su_ready),
    .out_data  (su_data)
  );

  tcs_div u_div (
    .clk, .rst,
    .in_valid  (su_valid),
    .in_ready  (su_ready),
    .in_data   (su_data),
    .out_valid (dv_valid),
    .out_ready (dv_ready),
    .out_data  (dv_data)
  );

  function automatic logic [SPAN_W-1:0] sat(input logic signed [NUM_W:0] x);
    if (x > (NUM_W+1)'((1 << (SPAN_W-1)) - 1)) begin
      return {1'b0, {(SPAN_W-1){1'b1}}};
    end else if (x < -(NUM_W+1)'(1 << (SPAN_W-1))) begin
      return {1'b1, {(SPAN_W-1){1'b0}}};
    end else begin
      return x[SPAN_W-1:0];
    end
  endfunction

  // sign fixup: bottom edge rounds up, top edge rounds down
  always_comb begin
    logic inc_b, inc_t;
    logic signed [NUM_W:0] qb, qt;
    inc_b = |dv_data.bot.rem;
    inc_t = |dv_data.top.rem;
    qb    = {1'b0, dv_data.bot.nq};
    qt    = {1'b0, dv_data.top.nq};
    if (dv_data.bot.dz) begin
      bot = '0;
    end else if (dv_data.bot.neg) begin
      bot = -qb;
    end else begin
      bot = qb + (NUM_W+1)'(inc_b);
    end
    if (dv_data.top.dz) begin
      top = '0;
    end else if (dv_data.top.neg) begin
      top = -(qt + (NUM_W+1)'(inc_t));
    end else begin
      top = qt;
    end
    // empty check uses the full values, before saturation
    cov   = dv_data.hit && (bot <= top);
    bot_s = sat(bot);
    top_s = sat(top);
  end

  // output register; color comes from the registers, which the user must
  // hold still while requests are in flight; the block does not enforce it.
  assign dv_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (dv_ready) begin
      m_tvalid <= dv_valid;
    end
    if (dv_ready && dv_valid) begin
      m_tuser <= cov;
      m_tdata <= cov ? {cfg.color, top_s, bot_s} : '0;
    end
  end

endmodule
